>>> design/srrg_pkg.sv
// ----------------------------------------------------------------------------
// srrg_pkg
// shared types and codes of the strict round-robin gather block
// ----------------------------------------------------------------------------
package srrg_pkg;

  // event kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // result error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_FULL      = 3'd1;
  localparam logic [2:0] ERR_BAD_INDEX = 3'd2;
  localparam logic [2:0] ERR_EXTRA_END = 3'd3;
  localparam logic [2:0] ERR_BACKLOG   = 3'd4;

  // register index (address bit 2 of the apb port)
  localparam logic REG_ACTIVE_INPUTS = 1'b0;

  localparam logic [3:0] ACTIVE_INPUTS_RESET = 4'd4;

  typedef struct packed {
    logic        kind;
    logic [2:0]  input_index;
    logic [31:0] packet_tag;
  } srrg_req_t;

  typedef struct packed {
    logic [31:0] packet_tag_res;
    logic [2:0]  source_input;
    logic        end_marker;
    logic [2:0]  error_code;
    logic        last;
  } srrg_res_t;

  // result push from the sequencer to the output register
  typedef struct packed {
    logic      push;
    srrg_res_t res;
  } srrg_push_t;

endpackage

>>> design/srrg_if.sv
// ----------------------------------------------------------------------------
// srrg_if
// valid/ready channels of the strict round-robin gather block
// ----------------------------------------------------------------------------
interface srrg_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  input_index;
  logic [31:0] packet_tag;

  modport source (output valid, kind, input_index, packet_tag, input ready);
  modport sink   (input valid, kind, input_index, packet_tag, output ready);
endinterface

interface srrg_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_tag_res;
  logic [2:0]  source_input;
  logic        end_marker;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, packet_tag_res, source_input, end_marker, error_code, last,
                  input ready);
  modport sink   (input valid, packet_tag_res, source_input, end_marker, error_code, last,
                  output ready);
endinterface

>>> design/srrg_ram.sv
// ----------------------------------------------------------------------------
// srrg_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/srrg_seq.sv
// ----------------------------------------------------------------------------
// srrg_seq
// queue sequencer: tag store, per-input head/count store, turn and close logic
// ----------------------------------------------------------------------------
module srrg_seq #(
  parameter int NUM_INPUTS  = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  srrg_pkg::srrg_req_t req_item,
  input  logic [3:0]          n_active,
  input  logic                out_free,
  output srrg_pkg::srrg_push_t push_out
);

  localparam int IDX_W   = $clog2(NUM_INPUTS);
  localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CTL_W   = CNT_W + SLOT_W;
  localparam int ST_DEPTH = NUM_INPUTS << SLOT_W;
  localparam int ST_AW   = IDX_W + SLOT_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PKT       = 3'd1;
  localparam logic [2:0] S_DRAIN_CTL = 3'd2;
  localparam logic [2:0] S_DRAIN_CHK = 3'd3;
  localparam logic [2:0] S_DRAIN_DAT = 3'd4;
  localparam logic [2:0] S_CLOSE     = 3'd5;
  localparam logic [2:0] S_EMIT      = 3'd6;

  logic [2:0]            state, state_next;
  logic [IDX_W-1:0]      turn, turn_next;
  logic [3:0]            ended, ended_next;
  logic [IDX_W-1:0]      idx_q, idx_q_next;
  logic [31:0]           tag_q, tag_q_next;
  logic [IDX_W-1:0]      close_i, close_i_next;
  logic [IDX_W-1:0]      drain_t, drain_t_next;
  logic [NUM_INPUTS-1:0] ctl_valid, ctl_valid_next;
  srrg_pkg::srrg_res_t   hold, hold_next;
  logic                  hold_valid, hold_valid_next;
  logic                  ctl_rvalid;

  logic                  ctl_we;
  logic [IDX_W-1:0]      ctl_waddr, ctl_raddr;
  logic [CTL_W-1:0]      ctl_wdata, ctl_rdata;
  logic                  st_we;
  logic [ST_AW-1:0]      st_waddr, st_raddr;
  logic [31:0]           st_rdata;

  logic [IDX_W-1:0]      turn_eff, turn_inc, req_idx;
  logic                  idx_ok;
  logic [SLOT_W-1:0]     cur_head, head_inc, slot;
  logic [CNT_W-1:0]      cur_cnt, cnt_inc, cnt_dec;
  logic [CNT_W:0]        slot_sum, head_sum;

  srrg_ram #(.WIDTH(CTL_W), .DEPTH(NUM_INPUTS)) u_ctl_ram (
    .clk   (clk),
    .we    (ctl_we),
    .waddr (ctl_waddr),
    .wdata (ctl_wdata),
    .raddr (ctl_raddr),
    .rdata (ctl_rdata)
  );

  srrg_ram #(.WIDTH(32), .DEPTH(ST_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (tag_q),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // head/count entry reads as zero until written after reset or close
  assign cur_head = ctl_rvalid ? ctl_rdata[SLOT_W-1:0] : '0;
  assign cur_cnt  = ctl_rvalid ? ctl_rdata[CTL_W-1:SLOT_W] : '0;
  assign cnt_inc  = cur_cnt + CNT_W'(1);
  assign cnt_dec  = cur_cnt - CNT_W'(1);

  assign slot_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_cnt);
  assign slot     = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                    SLOT_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : SLOT_W'(slot_sum);
  assign head_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(1);
  assign head_inc = (head_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ? '0 : SLOT_W'(head_sum);

  assign turn_eff = (4'(turn) >= n_active) ? '0 : turn;
  assign turn_inc = ((4'(turn) + 4'd1) >= n_active) ? '0 : IDX_W'(turn + IDX_W'(1));
  assign req_idx  = req_item.input_index[IDX_W-1:0];
  assign idx_ok   = {1'b0, req_item.input_index} < n_active;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    turn_next       = turn;
    ended_next      = ended;
    idx_q_next      = idx_q;
    tag_q_next      = tag_q;
    close_i_next    = close_i;
    drain_t_next    = drain_t;
    ctl_valid_next  = ctl_valid;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    ctl_we          = 1'b0;
    ctl_waddr       = idx_q;
    ctl_wdata       = {cnt_inc, cur_head};
    ctl_raddr       = turn;
    st_we           = 1'b0;
    st_waddr        = {idx_q, slot};
    st_raddr        = {turn, cur_head};
    push_out.push   = 1'b0;
    push_out.res    = hold;

    case (state)
      S_IDLE: begin
        turn_next = turn_eff;
        ctl_raddr = (req_item.kind == srrg_pkg::KIND_END) ? '0 : req_idx;
        if (req_valid) begin
          idx_q_next      = req_idx;
          tag_q_next      = req_item.packet_tag;
          hold_valid_next = 1'b0;
          hold_next       = '{packet_tag_res: '0, source_input: req_item.input_index,
                              end_marker: 1'b0, error_code: srrg_pkg::ERR_OK, last: 1'b0};
          if (!idx_ok) begin
            hold_next.error_code = srrg_pkg::ERR_BAD_INDEX;
            state_next           = S_EMIT;
          end else if (req_item.kind == srrg_pkg::KIND_PACKET) begin
            state_next = S_PKT;
          end else if (ended >= n_active) begin
            hold_next.error_code = srrg_pkg::ERR_EXTRA_END;
            state_next           = S_EMIT;
          end else begin
            ended_next = ended + 4'd1;
            if ((ended + 4'd1) == n_active) begin
              close_i_next = '0;
              state_next   = S_CLOSE;
            end
          end
        end
      end

      S_PKT: begin
        if (cur_cnt >= CNT_W'(QUEUE_DEPTH)) begin
          hold_next.error_code = srrg_pkg::ERR_FULL;
          state_next           = S_EMIT;
        end else begin
          st_we                 = 1'b1;
          ctl_we                = 1'b1;
          ctl_valid_next[idx_q] = 1'b1;
          state_next            = (idx_q == turn) ? S_DRAIN_CTL : S_IDLE;
        end
      end

      S_DRAIN_CTL: begin
        state_next = S_DRAIN_CHK;
      end

      S_DRAIN_CHK: begin
        if (cur_cnt == '0) begin
          // queue in turn is empty: the held tag is the last result
          state_next = S_EMIT;
        end else if (!hold_valid || out_free) begin
          push_out.push        = hold_valid;
          ctl_we               = 1'b1;
          ctl_waddr            = turn;
          ctl_wdata            = {cnt_dec, head_inc};
          ctl_valid_next[turn] = 1'b1;
          drain_t_next         = turn;
          turn_next            = turn_inc;
          ctl_raddr            = turn_inc;
          state_next           = S_DRAIN_DAT;
        end
      end

      S_DRAIN_DAT: begin
        hold_next       = '{packet_tag_res: st_rdata, source_input: 3'(drain_t),
                            end_marker: 1'b0, error_code: srrg_pkg::ERR_OK, last: 1'b0};
        hold_valid_next = 1'b1;
        state_next      = S_DRAIN_CHK;
      end

      S_CLOSE: begin
        ctl_raddr = close_i;
        if (!hold_valid || out_free) begin
          push_out.push   = hold_valid;
          hold_next       = '{packet_tag_res: '0, source_input: 3'(close_i), end_marker: 1'b1,
                              error_code: (cur_cnt != '0) ? srrg_pkg::ERR_BACKLOG
                                                          : srrg_pkg::ERR_OK,
                              last: 1'b0};
          hold_valid_next = 1'b1;
          if ((4'(close_i) + 4'd1) == n_active) begin
            // every active input closed: empty their queues
            for (int i = 0; i < NUM_INPUTS; i++) begin
              if (4'(i) < n_active) begin
                ctl_valid_next[i] = 1'b0;
              end
            end
            state_next = S_EMIT;
          end else begin
            close_i_next = close_i + IDX_W'(1);
            ctl_raddr    = close_i + IDX_W'(1);
          end
        end
      end

      S_EMIT: begin
        push_out.res.last = 1'b1;
        if (out_free) begin
          push_out.push   = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      turn       <= '0;
      ended      <= '0;
      ctl_valid  <= '0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      turn       <= turn_next;
      ended      <= ended_next;
      ctl_valid  <= ctl_valid_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_q      <= idx_q_next;
    tag_q      <= tag_q_next;
    close_i    <= close_i_next;
    drain_t    <= drain_t_next;
    hold       <= hold_next;
    ctl_rvalid <= ctl_valid_next[ctl_raddr];
  end

endmodule

>>> design/strict_round_robin_gather.sv
// ----------------------------------------------------------------------------
// strict_round_robin_gather
// merges packet tags from several input queues in strict round-robin turn
// ----------------------------------------------------------------------------
// sequence: a packet goes through S_PKT; in turn it goes on to S_DRAIN_CTL, then S_DRAIN_CHK
//   and S_DRAIN_DAT per forwarded tag, and S_EMIT for the final one; errors go to S_EMIT
// a plain end gives no result; a closing end runs S_CLOSE (one end marker per cycle while
//   the output register is free), then S_EMIT; requests are taken only in S_IDLE
// a stalled result holds the sequencer
// reset (rst, synchronous): queues empty, turn 0, end count 0, active_inputs 4
module strict_round_robin_gather #(
  parameter int NUM_INPUTS  = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  srrg_req_if.sink    req,
  srrg_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]           active_inputs;
  logic [3:0]           n_active;
  logic                 cfg_write;
  srrg_pkg::srrg_req_t  req_item;
  srrg_pkg::srrg_push_t push_in;
  logic                 out_free;
  logic                 out_valid;
  srrg_pkg::srrg_res_t  out_res;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == srrg_pkg::REG_ACTIVE_INPUTS);
  assign prdata    = (paddr[2] == srrg_pkg::REG_ACTIVE_INPUTS) ? {28'd0, active_inputs} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs <= srrg_pkg::ACTIVE_INPUTS_RESET;
    end else if (cfg_write) begin
      active_inputs <= pwdata[3:0];
    end
  end

  // effective active count, saturated to 1..NUM_INPUTS
  always_comb begin
    n_active = active_inputs;
    if (active_inputs == 4'd0) begin
      n_active = 4'd1;
    end else if (active_inputs > 4'(NUM_INPUTS)) begin
      n_active = 4'(NUM_INPUTS);
    end
  end

  // ---- sequencer with the queue memories ----
  assign req_item = '{kind: req.kind, input_index: req.input_index,
                      packet_tag: req.packet_tag};

  srrg_seq #(
    .NUM_INPUTS  (NUM_INPUTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_item  (req_item),
    .n_active  (n_active),
    .out_free  (out_free),
    .push_out  (push_in)
  );

  // ---- output register: lets the sequencer go on while a result waits ----
  assign out_free = ~out_valid | res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_in.push) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      out_res <= push_in.res;
    end
  end

  assign res.valid          = out_valid;
  assign res.packet_tag_res = out_res.packet_tag_res;
  assign res.source_input   = out_res.source_input;
  assign res.end_marker     = out_res.end_marker;
  assign res.error_code     = out_res.error_code;
  assign res.last           = out_res.last;

  // ---- checks ----
  // sequencer only pushes when the output register can take the transaction
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push_in.push |-> out_free)
    else $error("result pushed into a full output register");

  // error results and end markers carry no tag
  a_err_no_tag: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.error_code != srrg_pkg::ERR_OK || res.end_marker)) |->
      (res.packet_tag_res == 32'd0))
    else $error("tag present on error or end marker");

  // an end marker never carries a queue or index error
  a_end_codes: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.end_marker) |->
      (res.error_code == srrg_pkg::ERR_OK || res.error_code == srrg_pkg::ERR_BACKLOG))
    else $error("bad error code on end marker");

endmodule

>>> bench/tb_strict_round_robin_gather.sv
// ----------------------------------------------------------------------------
// tb_strict_round_robin_gather
// self-checking bench for the strict round-robin gather block: a directed
// table and then random phases of packet rounds, stray packets, end events
// and bad indexes, each phase under its own active input count; every result
// transaction is checked against a typed row result or a bench-side gather predictor
// ----------------------------------------------------------------------------
module tb_strict_round_robin_gather;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_IN        = 4;
  localparam int Q_DEPTH       = 8;
  localparam int PHASE_ITEMS   = 35;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam logic [2:0] ADDR_ACTIVE_INPUTS = {srrg_pkg::REG_ACTIVE_INPUTS, 2'b00};

  // active_inputs settings of the random phases, extremes included
  localparam logic [3:0] PHASE_SETTINGS [8] = '{
    4'd3, 4'd15, 4'd9, 4'd1, 4'd0, 4'd2, 4'd4, 4'd12
  };

  // directed table rows: either an event or a register write
  typedef enum logic {ROW_EVENT, ROW_SET_ACTIVE} row_op_e;

  typedef struct packed {
    row_op_e             op;
    srrg_pkg::srrg_req_t ev;
    logic                checked;   // expected result typed in the row
    srrg_pkg::srrg_res_t want;
    logic [3:0]          reg_value;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  srrg_req_if req_ch ();
  srrg_res_if res_ch ();

  strict_round_robin_gather #(
    .NUM_INPUTS  (NUM_IN),
    .QUEUE_DEPTH (Q_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // gather predictor state, mirrors the block after reset
  // --------------------------------------------------------------------------
  logic [31:0] tag_store  [NUM_IN][Q_DEPTH];
  logic [2:0]  queue_rd   [NUM_IN] = '{default: '0};
  logic [3:0]  queue_fill [NUM_IN] = '{default: '0};
  logic [2:0]  turn_owner = '0;
  logic [3:0]  ends_seen  = '0;
  logic [3:0]  active_reg = srrg_pkg::ACTIVE_INPUTS_RESET;

  srrg_pkg::srrg_res_t step_results [$];      // results of the transaction just accepted
  srrg_pkg::srrg_res_t pending_results [$];   // results still owed by the block
  logic        failed     = 1'b0;
  logic        gaps_on    = 1'b1;     // sender idle bursts
  logic        stalls_on  = 1'b1;     // receiver stall bursts
  int unsigned cycle_count = 0;

  function automatic srrg_pkg::srrg_req_t make_event(input logic kind,
                                                     input logic [2:0] idx,
                                                     input logic [31:0] tag);
    srrg_pkg::srrg_req_t ev;
    ev.kind        = kind;
    ev.input_index = idx;
    ev.packet_tag  = tag;
    return ev;
  endfunction

  function automatic srrg_pkg::srrg_res_t make_result(input logic [31:0] tag,
                                                      input logic [2:0] src,
                                                      input logic endm,
                                                      input logic [2:0] err,
                                                      input logic fin);
    srrg_pkg::srrg_res_t r;
    r.packet_tag_res = tag;
    r.source_input   = src;
    r.end_marker     = endm;
    r.error_code     = err;
    r.last           = fin;
    return r;
  endfunction

  // register value saturated to 1..NUM_IN
  function automatic int unsigned inputs_in_rotation();
    if (active_reg == 4'd0) return 1;
    if (active_reg > NUM_IN) return NUM_IN;
    return active_reg;
  endfunction

  // one accepted event: update queues, turn and end count, fill step_results
  function automatic void gather_step(input srrg_pkg::srrg_req_t ev);
    int unsigned         n;
    logic [2:0]          idx;
    logic [2:0]          t;
    logic [2:0]          slot;
    srrg_pkg::srrg_res_t r;
    n   = inputs_in_rotation();
    idx = ev.input_index;
    step_results.delete();
    if (turn_owner >= n) turn_owner = '0;
    if (idx >= n) begin
      step_results.push_back(make_result('0, idx, 1'b0, srrg_pkg::ERR_BAD_INDEX, 1'b0));
    end else if (ev.kind == srrg_pkg::KIND_PACKET) begin
      if (queue_fill[idx] >= Q_DEPTH) begin
        // tag dropped
        step_results.push_back(make_result('0, idx, 1'b0, srrg_pkg::ERR_FULL, 1'b0));
      end else begin
        slot = queue_rd[idx] + queue_fill[idx][2:0];
        tag_store[idx][slot] = ev.packet_tag;
        queue_fill[idx]++;
        // in turn: drain while the input now in turn has a backlog
        if (idx == turn_owner) begin
          while (queue_fill[turn_owner] != 0) begin
            t = turn_owner;
            step_results.push_back(make_result(tag_store[t][queue_rd[t]], t, 1'b0,
                                               srrg_pkg::ERR_OK, 1'b0));
            queue_rd[t]   = queue_rd[t] + 3'd1;
            queue_fill[t] = queue_fill[t] - 4'd1;
            turn_owner    = (t + 1 >= n) ? 3'd0 : t + 3'd1;
          end
        end
      end
    end else if (ends_seen >= n) begin
      step_results.push_back(make_result('0, idx, 1'b0, srrg_pkg::ERR_EXTRA_END, 1'b0));
    end else begin
      ends_seen++;
      // last end closes the stream: one marker per active input
      if (ends_seen == n) begin
        for (int i = 0; i < n; i++) begin
          step_results.push_back(make_result('0, 3'(i), 1'b1,
                                             (queue_fill[i] != 0) ? srrg_pkg::ERR_BACKLOG
                                                                  : srrg_pkg::ERR_OK,
                                             1'b0));
          queue_fill[i] = '0;
          queue_rd[i]   = '0;
        end
      end
    end
    if (step_results.size() != 0) begin
      r = step_results[step_results.size() - 1];
      r.last = 1'b1;
      step_results[step_results.size() - 1] = r;
    end
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one apb transaction, starting right after a rising edge; ends after an idle phase with psel low
  task automatic apb_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_ACTIVE_INPUTS;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_active_reg(input logic [3:0] value);
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== {28'd0, value}) begin
      $display("%0t: active_inputs read mismatch: expected %h, actual %h",
               $time, {28'd0, value}, rdata);
      failed = 1'b1;
    end
  endtask

  // register write only once the block has gone quiet
  task automatic set_active(input logic [3:0] value);
    logic [31:0] rdata;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an end or a queued packet gives no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, {28'($urandom), value}, rdata);
    active_reg = value;
    if (turn_owner >= inputs_in_rotation()) turn_owner = '0;
    check_active_reg(value);
  endtask

  // present one event, wait for the transaction, then queue what it should give
  task automatic drive_event(input srrg_pkg::srrg_req_t ev, input logic checked,
                             input srrg_pkg::srrg_res_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= ev.kind;
    req_ch.input_index <= ev.input_index;
    req_ch.packet_tag  <= ev.packet_tag;
    do @(posedge clk); while (!req_ch.ready);
    gather_step(ev);
    if (checked) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // receiver: random stall bursts while stalls_on
  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 10);
      end
      res_ch.ready <= (hold == 0);
    end
  end

  // --------------------------------------------------------------------------
  // result checking against the oldest owed result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    srrg_pkg::srrg_res_t got;
    srrg_pkg::srrg_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = make_result(res_ch.packet_tag_res, res_ch.source_input, res_ch.end_marker,
                        res_ch.error_code, res_ch.last);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: tag=%h src=%0d end=%0b err=%0d last=%0b",
                 $time, got.packet_tag_res, got.source_input, got.end_marker,
                 got.error_code, got.last);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.packet_tag_res !== want.packet_tag_res
            || got.source_input !== want.source_input
            || got.end_marker !== want.end_marker
            || got.error_code !== want.error_code
            || got.last !== want.last) begin
          $display("%0t: result mismatch: expected tag=%h src=%0d end=%0b err=%0d last=%0b",
                   $time, want.packet_tag_res, want.source_input, want.end_marker,
                   want.error_code, want.last);
          $display("%0t:                  actual   tag=%h src=%0d end=%0b err=%0d last=%0b",
                   $time, got.packet_tag_res, got.source_input, got.end_marker,
                   got.error_code, got.last);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    directed_row_t directed_rows [$];
    directed_row_t row;
    int unsigned   order [NUM_IN];
    int unsigned   n;
    int unsigned   sent;
    int unsigned   pick;
    int unsigned   j;
    int unsigned   swap;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= srrg_pkg::KIND_PACKET;
    req_ch.input_index <= '0;
    req_ch.packet_tag  <= '0;

    // directed table, four inputs after reset, turn at input 0
    row = '0;
    row.op = ROW_EVENT;
    // extremes of the tag, each in turn: forwarded at once
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd0, 32'h0000_0000);
    row.checked = 1'b1;
    row.want = make_result(32'h0000_0000, 3'd0, 1'b0, srrg_pkg::ERR_OK, 1'b1);
    directed_rows.push_back(row);
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd1, 32'hFFFF_FFFF);
    row.want = make_result(32'hFFFF_FFFF, 3'd1, 1'b0, srrg_pkg::ERR_OK, 1'b1);
    directed_rows.push_back(row);
    // bad index, for a packet and for an end
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd7, 32'h1234_5678);
    row.want = make_result('0, 3'd7, 1'b0, srrg_pkg::ERR_BAD_INDEX, 1'b1);
    directed_rows.push_back(row);
    row.ev = make_event(srrg_pkg::KIND_END, 3'd4, 32'hDEAD_BEEF);
    row.want = make_result('0, 3'd4, 1'b0, srrg_pkg::ERR_BAD_INDEX, 1'b1);
    directed_rows.push_back(row);
    // packet out of turn is held, then released by the late input
    row.checked = 1'b0;
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd3, 32'hA5A5_A5A5);
    directed_rows.push_back(row);
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd2, 32'h5A5A_5A5A);
    directed_rows.push_back(row);
    // fill input 1 while input 0 holds the turn, then overflow it
    for (int i = 0; i < Q_DEPTH; i++) begin
      row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd1, 32'h1000_0000 + i);
      directed_rows.push_back(row);
    end
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd1, 32'h1FFF_FFFF);
    row.checked = 1'b1;
    row.want = make_result('0, 3'd1, 1'b0, srrg_pkg::ERR_FULL, 1'b1);
    directed_rows.push_back(row);
    // late input arrives: forwards input 0 and one tag of input 1
    row.checked = 1'b0;
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd0, 32'h0000_0C0C);
    directed_rows.push_back(row);
    // single input: one end closes the stream
    row.op = ROW_SET_ACTIVE;
    row.reg_value = 4'd0;
    directed_rows.push_back(row);
    row.op = ROW_EVENT;
    row.checked = 1'b1;
    row.ev = make_event(srrg_pkg::KIND_END, 3'd0, '0);
    row.want = make_result('0, 3'd0, 1'b1, srrg_pkg::ERR_OK, 1'b1);
    directed_rows.push_back(row);
    row.want = make_result('0, 3'd0, 1'b0, srrg_pkg::ERR_EXTRA_END, 1'b1);
    directed_rows.push_back(row);
    // packets after close are handled as usual
    row.checked = 1'b0;
    row.ev = make_event(srrg_pkg::KIND_PACKET, 3'd0, 32'h8000_0001);
    directed_rows.push_back(row);
    // two inputs: the second end closes with input 1 still backlogged
    row.op = ROW_SET_ACTIVE;
    row.reg_value = 4'd2;
    directed_rows.push_back(row);
    row.op = ROW_EVENT;
    row.ev = make_event(srrg_pkg::KIND_END, 3'd1, 32'h0F0F_0F0F);
    directed_rows.push_back(row);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    check_active_reg(srrg_pkg::ACTIVE_INPUTS_RESET);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_SET_ACTIVE) begin
        set_active(directed_rows[i].reg_value);
      end else begin
        drive_event(directed_rows[i].ev, directed_rows[i].checked, directed_rows[i].want);
      end
    end

    // random phases; the last one runs without idling on either side
    foreach (PHASE_SETTINGS[p]) begin
      set_active(PHASE_SETTINGS[p]);
      if (p == $size(PHASE_SETTINGS) - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n    = inputs_in_rotation();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // full round, one packet per input in shuffled order
          for (int i = 0; i < n; i++) order[i] = i;
          for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
          end
          for (int i = 0; i < n; i++) begin
            drive_event(make_event(srrg_pkg::KIND_PACKET, 3'(order[i]), $urandom),
                        1'b0, '0);
          end
          sent += n;
        end else if (pick < 80) begin
          // stray packet, builds backlog and eventually overflow
          drive_event(make_event(srrg_pkg::KIND_PACKET, 3'($urandom_range(0, n - 1)),
                                 $urandom), 1'b0, '0);
          sent++;
        end else if (pick < 88) begin
          drive_event(make_event(srrg_pkg::KIND_END, 3'($urandom_range(0, n - 1)),
                                 $urandom), 1'b0, '0);
          sent++;
        end else begin
          // noise: any kind, any index
          drive_event(make_event(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                 $urandom), 1'b0, '0);
          sent++;
        end
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
